// File: sv/bsm16k_pkg.sv
// ============================================================================
// Sunsoft-4 style bank mapper - shared definitions
// Access kinds, target codes, register indexes and field widths.
// ============================================================================
`default_nettype none

package bsm16k_pkg;

    // Input word fields
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned WDATA_W = 8;
    localparam int unsigned S_DATA_W = 32;   // bus_address + write_data, byte padded

    // Result word fields
    localparam int unsigned TGT_W   = 3;
    localparam int unsigned MADDR_W = 19;
    localparam int unsigned M_DATA_W = 24;   // target + mapped_address + is_write

    // Configuration port
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // Behaviour constants
    localparam int unsigned CNT_W          = 11;
    localparam logic [CNT_W-1:0] CNT_MAX   = 11'd2047;
    localparam logic [CNT_W-1:0] FALLBACK_READS = 11'd1784;
    localparam logic [7:0] NT_CHR_FORCE    = 8'd128;
    localparam logic [12:0] WRAM_MASK      = 13'h1FFF;   // 8K work RAM

    typedef enum logic [KIND_W-1:0] {
        KIND_CPU_READ  = 2'd0,
        KIND_CPU_WRITE = 2'd1,
        KIND_PPU       = 2'd2,
        KIND_NONE      = 2'd3
    } kind_t;

    typedef enum logic [TGT_W-1:0] {
        TGT_NONE    = 3'd0,
        TGT_PRG_MAIN = 3'd1,
        TGT_PRG_EXT = 3'd2,
        TGT_WRAM    = 3'd3,
        TGT_CHR     = 3'd4,
        TGT_NT_RAM  = 3'd5
    } target_t;

    typedef enum logic [1:0] {
        MIR_VERTICAL   = 2'd0,
        MIR_HORIZONTAL = 2'd1,
        MIR_SINGLE_A   = 2'd2,
        MIR_SINGLE_B   = 2'd3
    } mirror_t;

    typedef enum logic [1:0] {
        REG_EXT_ROM_PRESENT = 2'd0,
        REG_CHR_IS_RAM      = 2'd1,
        REG_CHR_BANK_MASK   = 2'd2,
        REG_PRG_BANK_MASK   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        target_t            target;
        logic [MADDR_W-1:0] mapped_address;
        logic               is_write;
    } result_t;

endpackage

`default_nettype wire

// File: sv/bank_switch_mapper_sixteen_k_prg_top.sv
// ============================================================================
// Sunsoft-4 style bank mapper - top level
// Translates each CPU read, CPU write or PPU access into a target memory and
// a byte address, and keeps the mapper's bank registers and read counter.
// ============================================================================
//
//  Channel   Direction  Handshake          Contents
//  s_        in         s_tvalid/s_tready  one bus access word
//  m_        out        m_tvalid/m_tready  one translated access word
//  APB       in/out     psel/penable       four configuration registers
//
// Each word passes through an input register and a result register, and
// m_tvalid rises when the word moves on into the result register. One word
// can be taken in every cycle while the result register is not stalled.
// The bank registers and the read counter are updated as a word
// moves from the input register to the result register, so each word sees the
// effect of every earlier one. When the result register is stalled the input
// register still takes one more word before s_tready falls. Reset is
// synchronous and active low; it empties both registers and restores the
// bank state and configuration to their defaults.
`default_nettype none

module bank_switch_mapper_sixteen_k_prg_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input stream
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // [15:0] bus_address, [23:16] write_data, [31:24] zero
    input  wire logic [bsm16k_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] access_kind
    input  wire logic [bsm16k_pkg::KIND_W-1:0]     s_tuser,
    // Result stream
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // [2:0] target, [21:3] mapped_address, [22] is_write, [23] zero
    output      logic [bsm16k_pkg::M_DATA_W-1:0]   m_tdata,
    // Configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bsm16k_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [bsm16k_pkg::PDATA_W-1:0]    pwdata,
    output      logic [bsm16k_pkg::PDATA_W-1:0]    prdata,
    output      logic                              pready
);
    import bsm16k_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       ext_rom_present_reg;
    logic       chr_is_ram_reg;
    logic [7:0] chr_bank_mask_reg;
    logic [3:0] prg_bank_mask_reg;
    logic       cfg_write;
    reg_idx_t   cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_rom_present_reg <= 1'b0;
            chr_is_ram_reg      <= 1'b0;
            chr_bank_mask_reg   <= 8'hFF;
            prg_bank_mask_reg   <= 4'd7;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_EXT_ROM_PRESENT: ext_rom_present_reg <= pwdata[0];
                REG_CHR_IS_RAM:      chr_is_ram_reg      <= pwdata[0];
                REG_CHR_BANK_MASK:   chr_bank_mask_reg   <= pwdata[7:0];
                REG_PRG_BANK_MASK:   prg_bank_mask_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_EXT_ROM_PRESENT: prdata[0]   = ext_rom_present_reg;
            REG_CHR_IS_RAM:      prdata[0]   = chr_is_ram_reg;
            REG_CHR_BANK_MASK:   prdata[7:0] = chr_bank_mask_reg;
            REG_PRG_BANK_MASK:   prdata[3:0] = prg_bank_mask_reg;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic               in_valid_reg;
    kind_t              kind_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [WDATA_W-1:0] wdata_reg;
    logic               advance;     // input register moves into the result register
    logic               s_fire;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg  <= kind_t'(s_tuser);
            addr_reg  <= s_tdata[ADDR_W-1:0];
            wdata_reg <= s_tdata[ADDR_W +: WDATA_W];
        end
    end

    // ------------------------------------------------------------------
    // Mapper state
    // ------------------------------------------------------------------
    logic [7:0]       chr_banks_reg [4];
    logic [7:0]       nt_bank_a_reg, nt_bank_b_reg;
    logic             nt_from_chr_reg;
    mirror_t          mirror_mode_reg;
    logic [2:0]       prg_bank_reg;
    logic             chip_select_reg;
    logic             active_chip_reg;
    logic [CNT_W-1:0] read_counter_reg;

    logic [7:0]       chr_banks_next [4];
    logic [7:0]       nt_bank_a_next, nt_bank_b_next;
    logic             nt_from_chr_next;
    mirror_t          mirror_mode_next;
    logic [2:0]       prg_bank_next;
    logic             chip_select_next;
    logic             active_chip_next;
    logic [CNT_W-1:0] read_counter_next;

    result_t          res;

    // Translation and register decode for the word in the input register.
    always_comb begin
        logic [13:0] low;
        logic [13:0] ppu_a;
        logic [7:0]  bank;
        logic [18:0] chr_raw;
        logic        use_b;
        logic [7:0]  nt;
        logic [7:0]  nt_masked;
        logic        reselect;

        chr_banks_next    = chr_banks_reg;
        nt_bank_a_next    = nt_bank_a_reg;
        nt_bank_b_next    = nt_bank_b_reg;
        nt_from_chr_next  = nt_from_chr_reg;
        mirror_mode_next  = mirror_mode_reg;
        prg_bank_next     = prg_bank_reg;
        chip_select_next  = chip_select_reg;
        active_chip_next  = active_chip_reg;
        read_counter_next = read_counter_reg;

        res       = '{target: TGT_NONE, mapped_address: '0, is_write: 1'b0};
        low       = addr_reg[13:0];
        ppu_a     = addr_reg[13:0];
        bank      = chr_banks_reg[ppu_a[12:11]];
        chr_raw   = {bank, ppu_a[10:0]};
        use_b     = 1'b0;
        nt        = '0;
        nt_masked = '0;
        reselect  = 1'b0;

        unique case (kind_reg)
            KIND_CPU_READ: begin
                if (addr_reg < 16'h6000) begin
                    res.target = TGT_NONE;
                end else if (addr_reg < 16'h8000) begin
                    res.target         = TGT_WRAM;
                    res.mapped_address = {6'd0, addr_reg[12:0] & WRAM_MASK};
                end else if (addr_reg < 16'hC000) begin
                    // Switchable window; the counter may drop back to the main chip.
                    if (read_counter_reg != CNT_MAX) begin
                        read_counter_next = read_counter_reg + 1'b1;
                    end
                    if (read_counter_next == FALLBACK_READS) begin
                        active_chip_next = 1'b0;
                    end
                    if (active_chip_next) begin
                        res.target         = TGT_PRG_EXT;
                        res.mapped_address = {2'd0, prg_bank_reg, low};
                    end else begin
                        res.target         = TGT_PRG_MAIN;
                        res.mapped_address = {2'd0, prg_bank_reg & prg_bank_mask_reg[2:0], low};
                    end
                end else begin
                    // Fixed last bank.
                    res.target         = TGT_PRG_MAIN;
                    res.mapped_address = {1'b0, prg_bank_mask_reg, low};
                end
            end
            KIND_CPU_WRITE: begin
                if (addr_reg == 16'h6000) begin
                    if (wdata_reg == 8'd0) begin
                        read_counter_next = '0;
                        reselect          = 1'b1;
                    end
                end else if (addr_reg >= 16'h6000 && addr_reg < 16'h8000) begin
                    res.target         = TGT_WRAM;
                    res.mapped_address = {6'd0, addr_reg[12:0] & WRAM_MASK};
                    res.is_write       = 1'b1;
                end else if (addr_reg >= 16'h8000) begin
                    unique case (addr_reg[14:12])
                        3'd0, 3'd1, 3'd2, 3'd3: begin
                            chr_banks_next[addr_reg[13:12]] = wdata_reg;
                            reselect = 1'b1;
                        end
                        3'd4: nt_bank_a_next = wdata_reg;
                        3'd5: nt_bank_b_next = wdata_reg;
                        3'd6: begin
                            mirror_mode_next = mirror_t'(wdata_reg[1:0]);
                            nt_from_chr_next = wdata_reg[4];
                        end
                        default: begin
                            prg_bank_next    = wdata_reg[2:0];
                            chip_select_next = !wdata_reg[3];
                            reselect         = 1'b1;
                        end
                    endcase
                end
                if (reselect) begin
                    active_chip_next = ext_rom_present_reg && chip_select_next;
                end
            end
            KIND_PPU: begin
                if (ppu_a < 14'h2000) begin
                    res.target         = TGT_CHR;
                    res.mapped_address = {1'b0, chr_raw[17:0] & {chr_bank_mask_reg, 10'h3FF}};
                end else if (ppu_a < 14'h3F00) begin
                    unique case (mirror_mode_reg)
                        MIR_VERTICAL:   use_b = ppu_a[10];
                        MIR_HORIZONTAL: use_b = ppu_a[11];
                        MIR_SINGLE_A:   use_b = 1'b0;
                        MIR_SINGLE_B:   use_b = 1'b1;
                        default:        use_b = 1'b0;
                    endcase
                    nt        = use_b ? nt_bank_b_reg : nt_bank_a_reg;
                    nt_masked = (nt | NT_CHR_FORCE) & chr_bank_mask_reg;
                    if (!chr_is_ram_reg && nt_from_chr_reg) begin
                        res.target         = TGT_CHR;
                        res.mapped_address = {1'b0, nt_masked, ppu_a[9:0]};
                    end else begin
                        res.target         = TGT_NT_RAM;
                        res.mapped_address = {8'd0, use_b, ppu_a[9:0]};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                chr_banks_reg[i] <= '0;
            end
            nt_bank_a_reg    <= '0;
            nt_bank_b_reg    <= '0;
            nt_from_chr_reg  <= 1'b0;
            mirror_mode_reg  <= MIR_VERTICAL;
            prg_bank_reg     <= '0;
            chip_select_reg  <= 1'b0;
            active_chip_reg  <= 1'b0;
            read_counter_reg <= '0;
        end else if (advance) begin
            chr_banks_reg    <= chr_banks_next;
            nt_bank_a_reg    <= nt_bank_a_next;
            nt_bank_b_reg    <= nt_bank_b_next;
            nt_from_chr_reg  <= nt_from_chr_next;
            mirror_mode_reg  <= mirror_mode_next;
            prg_bank_reg     <= prg_bank_next;
            chip_select_reg  <= chip_select_next;
            active_chip_reg  <= active_chip_next;
            read_counter_reg <= read_counter_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic    out_valid_reg;
    result_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.is_write, out_reg.mapped_address, out_reg.target};

endmodule

`default_nettype wire
